// ----- rtl/sliding_window_receiver_macros.svh -----
// Assertion macros shared by the sliding window receiver RTL.
`ifndef SLIDING_WINDOW_RECEIVER_MACROS_SVH
`define SLIDING_WINDOW_RECEIVER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SWR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swr same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SWR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swr next-cycle check failed");

`endif

// ----- rtl/swr_pkg.sv -----
// Shared types and constants of the sliding window receiver.
package swr_pkg;

   localparam int SEQ_W      = 32;
   localparam int BYTE_W     = 8;
   localparam int WS_W       = 5;
   localparam int BS_W       = 6;
   localparam int ACK_W      = 6;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   localparam int WS_RESET = 4;
   localparam int BS_RESET = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BUFFER = 1'b1;

   localparam logic KIND_DATA = 1'b0;
   localparam logic KIND_ACK  = 1'b1;

   typedef enum logic [1:0] {
      OUT_ACK,
      OUT_FINAL,
      OUT_BYTE
   } out_sel_type;

   typedef struct packed {
      logic        capture;
      logic        div_step;
      logic        store;
      logic        walk_init;
      logic        walk_step;
      logic        walk_commit;
      logic        walk_inorder;
      logic        set_finished;
      logic        fl_init;
      logic        fl_full;
      logic        fl_next;
      logic        restart;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic finished;
      logic go_end;
      logic go_data;
      logic div_done;
      logic in_window;
      logic slot_filled;
      logic slot_is_next;
      logic walk_go;
      logic free_zero;
      logic end_cnt_zero;
      logic fl_last;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/sliding_window_receiver.sv -----
// Top level of the selective-repeat sliding window receiver.
//
// Segments arrive on the req_ channel (valid/ready). A segment with a bad
// checksum, one outside the window, and every segment after the end segment
// is taken and dropped without a result. Results leave on the rsp_ channel
// (valid/ready); rsp_last marks the final beat caused by one segment.
// The window and buffer sizes are written through the csr_ port; the user
// must do so only while idle, which the block itself does not enforce.
// One segment is handled at a time. A data segment passes the bit-serial
// remainder of the sequence number by the buffer size, the window check, a
// walk over the filled slots when it walks, and the loading of its ack. A
// flush reads each byte from the registered slot memory before loading it.
// A segment outside the window frees the input after the window check, one
// with a bad checksum frees it on capture. The end segment loads its final
// ack and then flushes the stored bytes from slot zero up.
// The next segment is taken while the last beat still waits in the output
// register. When rsp_ready is low the beat is held and work stalls only once
// the next beat is due. Reset sets all window state to its defaults, clears
// the filled marks and loads the default sizes; the block is ready once it drops.
module sliding_window_receiver #(
   parameter int BUF_DEPTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [swr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [swr_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [swr_pkg::SEQ_W-1:0]      req_seq_num,
   input  logic [swr_pkg::BYTE_W-1:0]     req_data_byte,
   input  logic                           req_end_flag,
   input  logic                           req_checksum_ok,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           rsp_kind,
   output logic [swr_pkg::ACK_W-1:0]      rsp_ack_next,
   output logic [swr_pkg::ACK_W-1:0]      rsp_ack_free,
   output logic                           rsp_final_ack,
   output logic [swr_pkg::BYTE_W-1:0]     rsp_out_byte,
   output logic                           rsp_last
);
   import swr_pkg::*;

   `include "sliding_window_receiver_macros.svh"

   dp_cmd_type    cmd;
   dp_status_type st;

   swr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .st        (st),
      .cmd       (cmd)
   );

   swr_datapath #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_seq_num     (req_seq_num),
      .req_data_byte   (req_data_byte),
      .req_end_flag    (req_end_flag),
      .req_checksum_ok (req_checksum_ok),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_kind        (rsp_kind),
      .rsp_ack_next    (rsp_ack_next),
      .rsp_ack_free    (rsp_ack_free),
      .rsp_final_ack   (rsp_final_ack),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last),
      .cmd             (cmd),
      .st              (st)
   );

   // A beat is never loaded over one that has not been taken.
   `SWR_ASSERT_IMPL(a_load_into_free, clock, reset, cmd.out_load, st.out_free)
   // Nothing is stored once the end segment has been seen.
   `SWR_ASSERT_IMPL(a_no_store_after_end, clock, reset, cmd.store, !st.finished)
   // An accepted end segment keeps the block busy for its final ack.
   `SWR_ASSERT_NEXT(a_end_busy, clock, reset, req_valid && req_ready && st.go_end, !req_ready)

endmodule

// ----- rtl/swr_ctrl.sv -----
// Controller state machine of the sliding window receiver.
module swr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  swr_pkg::dp_status_type st,
   output swr_pkg::dp_cmd_type   cmd
);
   import swr_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_CHECK,
      S_WALK,
      S_POST,
      S_FL_RD,
      S_FL_WR,
      S_ACK,
      S_END_ACK
   } state_type;

   state_type state_ff, state_in;
   logic      is_end_ff, is_end_in;
   logic      inorder_ff, inorder_in;

   assign req_ready = (state_ff == S_IDLE) && !reset;

   always_comb begin
      state_in   = state_ff;
      is_end_in  = is_end_ff;
      inorder_in = inorder_ff;
      cmd        = '0;
      cmd.out_sel = OUT_ACK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (st.go_end) begin
                  state_in = S_END_ACK;
               end else if (st.go_data) begin
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (st.div_done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (!st.in_window) begin
               state_in = S_IDLE;
            end else if (!st.slot_filled) begin
               cmd.store = 1'b1;
               if (st.slot_is_next) begin
                  cmd.walk_init = 1'b1;
                  inorder_in    = 1'b1;
                  state_in      = S_WALK;
               end else begin
                  state_in = S_POST;
               end
            end else begin
               cmd.walk_init = 1'b1;
               inorder_in    = 1'b0;
               state_in      = S_WALK;
            end
         end
         S_WALK: begin
            if (st.walk_go) begin
               cmd.walk_step = 1'b1;
            end else begin
               cmd.walk_commit  = 1'b1;
               cmd.walk_inorder = inorder_ff;
               state_in         = S_POST;
            end
         end
         S_POST: begin
            // A full buffer is emitted before its ack.
            if (st.free_zero) begin
               cmd.fl_init = 1'b1;
               cmd.fl_full = 1'b1;
               is_end_in   = 1'b0;
               state_in    = S_FL_RD;
            end else begin
               state_in = S_ACK;
            end
         end
         S_FL_RD: begin
            state_in = S_FL_WR;
         end
         S_FL_WR: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_BYTE;
               cmd.out_last = is_end_ff && st.fl_last;
               cmd.fl_next  = 1'b1;
               if (st.fl_last) begin
                  state_in = is_end_ff ? S_IDLE : S_ACK;
               end else begin
                  state_in = S_FL_RD;
               end
            end
         end
         S_ACK: begin
            if (st.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = OUT_ACK;
               cmd.out_last = 1'b1;
               cmd.restart  = st.free_zero;
               state_in     = S_IDLE;
            end
         end
         S_END_ACK: begin
            if (st.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_sel      = OUT_FINAL;
               cmd.out_last     = st.end_cnt_zero;
               cmd.fl_init      = 1'b1;
               cmd.set_finished = 1'b1;
               is_end_in        = 1'b1;
               state_in         = st.end_cnt_zero ? S_IDLE : S_FL_RD;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         is_end_ff  <= 1'b0;
         inorder_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         is_end_ff  <= is_end_in;
         inorder_ff <= inorder_in;
      end
   end

endmodule

// ----- rtl/swr_datapath.sv -----
// Datapath of the sliding window receiver: window state, slot memory, remainder unit, output.
module swr_datapath #(
   parameter int BUF_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [swr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [swr_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic [swr_pkg::SEQ_W-1:0]           req_seq_num,
   input  logic [swr_pkg::BYTE_W-1:0]          req_data_byte,
   input  logic                                req_end_flag,
   input  logic                                req_checksum_ok,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic                                rsp_kind,
   output logic [swr_pkg::ACK_W-1:0]           rsp_ack_next,
   output logic [swr_pkg::ACK_W-1:0]           rsp_ack_free,
   output logic                                rsp_final_ack,
   output logic [swr_pkg::BYTE_W-1:0]          rsp_out_byte,
   output logic                                rsp_last,
   input  swr_pkg::dp_cmd_type                 cmd,
   output swr_pkg::dp_status_type              st
);
   import swr_pkg::*;

   localparam int CW    = $clog2(BUF_DEPTH + 1);
   localparam int IW    = $clog2(BUF_DEPTH);
   localparam int SW    = ((CW > WS_W) ? CW : WS_W) + 1;
   localparam int DCW   = $clog2(SEQ_W);
   localparam int B_RST = (BS_RESET > BUF_DEPTH) ? BUF_DEPTH : BS_RESET;
   localparam int L_RST = (WS_RESET < B_RST - 1) ? WS_RESET : B_RST - 1;

   function automatic logic [CW-1:0] win_end(input logic [CW-1:0] from,
                                             input logic [WS_W-1:0] ws,
                                             input logic [CW-1:0] top);
      logic [SW-1:0] sum;
      sum = SW'(from) + SW'(ws);
      return (sum > SW'(top)) ? top : sum[CW-1:0];
   endfunction

   // Configuration registers.
   logic [WS_W-1:0] ws_ff;
   logic [BS_W-1:0] bs_ff;

   // Window state.
   logic [BUF_DEPTH-1:0] filled_ff, filled_in;
   logic [CW-1:0]        lr_ff, lr_in, la_ff, la_in, ne_ff, ne_in, free_ff, free_in;
   logic                 finished_ff, finished_in;

   // Captured segment and remainder unit.
   logic [SEQ_W-1:0]  seq_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [CW-1:0]     rem_ff;
   logic [DCW-1:0]    dcnt_ff;
   logic [CW:0]       rem_try;

   // Walk and flush counters.
   logic [CW-1:0] widx_ff, fidx_ff, fcnt_ff;

   // Slot memory.
   logic [BYTE_W-1:0] mem [BUF_DEPTH];
   logic [BYTE_W-1:0] rd_ff;

   // Output register.
   logic              rsp_valid_ff;
   logic              kind_ff, final_ff, last_ff;
   logic [ACK_W-1:0]  next_ff, free_out_ff;
   logic [BYTE_W-1:0] obyte_ff;

   logic [CW-1:0] buf_b, top, end_cnt, lr_walk;
   logic          out_free;

   always_comb begin
      if (bs_ff == '0) begin
         buf_b = CW'(1);
      end else if ({1'b0, bs_ff} > (BS_W + 1)'(BUF_DEPTH)) begin
         buf_b = CW'(BUF_DEPTH);
      end else begin
         buf_b = bs_ff[CW-1:0];
      end
   end

   assign top      = buf_b - CW'(1);
   assign end_cnt  = (buf_b > free_ff) ? (buf_b - free_ff) : '0;
   assign lr_walk  = (widx_ff != '0) ? (widx_ff - CW'(1)) : '0;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign rem_try  = {rem_ff, seq_ff[SEQ_W-1]};

   // Status toward the controller.
   always_comb begin
      st.finished     = finished_ff;
      st.go_end       = req_checksum_ok && req_end_flag && !finished_ff;
      st.go_data      = req_checksum_ok && !req_end_flag && !finished_ff;
      st.div_done     = (dcnt_ff == DCW'(SEQ_W - 1));
      st.in_window    = (rem_ff >= lr_ff) && (rem_ff <= la_ff);
      st.slot_filled  = filled_ff[rem_ff[IW-1:0]];
      st.slot_is_next = (rem_ff == ne_ff);
      st.walk_go      = (widx_ff < buf_b) && filled_ff[widx_ff[IW-1:0]];
      st.free_zero    = (free_ff == '0);
      st.end_cnt_zero = (end_cnt == '0);
      st.fl_last      = (fidx_ff == fcnt_ff - CW'(1));
      st.out_free     = out_free;
   end

   // Next window state.
   always_comb begin
      filled_in   = filled_ff;
      lr_in       = lr_ff;
      la_in       = la_ff;
      ne_in       = ne_ff;
      free_in     = free_ff;
      finished_in = finished_ff;
      if (cmd.store) begin
         filled_in[rem_ff[IW-1:0]] = 1'b1;
         if (free_ff != '0) begin
            free_in = free_ff - CW'(1);
         end
      end
      if (cmd.walk_commit) begin
         ne_in = widx_ff;
         if (cmd.walk_inorder) begin
            lr_in = lr_walk;
            la_in = win_end(lr_walk, ws_ff, top);
         end
      end
      if (cmd.restart) begin
         filled_in = '0;
         free_in   = buf_b;
         lr_in     = '0;
         ne_in     = '0;
         la_in     = win_end('0, ws_ff, top);
      end
      if (cmd.set_finished) begin
         finished_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff       <= WS_W'(WS_RESET);
         bs_ff       <= BS_W'(BS_RESET);
         filled_ff   <= '0;
         lr_ff       <= '0;
         la_ff       <= CW'(L_RST);
         ne_ff       <= '0;
         free_ff     <= CW'(B_RST);
         finished_ff <= 1'b0;
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_WINDOW: ws_ff <= csr_wdata[WS_W-1:0];
               CSR_BUFFER: bs_ff <= csr_wdata[BS_W-1:0];
               default: begin
               end
            endcase
         end
         filled_ff   <= filled_in;
         lr_ff       <= lr_in;
         la_ff       <= la_in;
         ne_ff       <= ne_in;
         free_ff     <= free_in;
         finished_ff <= finished_in;
      end
   end

   // Remainder of the sequence number by the buffer size, one bit per cycle.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         seq_ff  <= req_seq_num;
         byte_ff <= req_data_byte;
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         seq_ff  <= {seq_ff[SEQ_W-2:0], 1'b0};
         dcnt_ff <= dcnt_ff + DCW'(1);
         if (rem_try >= {1'b0, buf_b}) begin
            rem_ff <= CW'(rem_try - {1'b0, buf_b});
         end else begin
            rem_ff <= rem_try[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         widx_ff <= lr_ff;
      end else if (cmd.walk_step) begin
         widx_ff <= widx_ff + CW'(1);
      end
      if (cmd.fl_init) begin
         fidx_ff <= '0;
         fcnt_ff <= cmd.fl_full ? buf_b : end_cnt;
      end else if (cmd.fl_next) begin
         fidx_ff <= fidx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.store) begin
         mem[rem_ff[IW-1:0]] <= byte_ff;
      end
      rd_ff <= mem[fidx_ff[IW-1:0]];
   end

   // Output register; a new beat loads when it is empty or the previous one is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         kind_ff     <= (cmd.out_sel == OUT_BYTE) ? KIND_DATA : KIND_ACK;
         next_ff     <= (cmd.out_sel == OUT_ACK) ? ACK_W'(ne_ff) : '0;
         free_out_ff <= (cmd.out_sel == OUT_BYTE) ? '0 : ACK_W'(free_ff);
         final_ff    <= (cmd.out_sel == OUT_FINAL);
         obyte_ff    <= (cmd.out_sel == OUT_BYTE) ? rd_ff : '0;
         last_ff     <= cmd.out_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = kind_ff;
   assign rsp_ack_next  = next_ff;
   assign rsp_ack_free  = free_out_ff;
   assign rsp_final_ack = final_ff;
   assign rsp_out_byte  = obyte_ff;
   assign rsp_last      = last_ff;

endmodule
